// ----- rtl/core/dcce_pkg.sv -----
// ----------------------------------------------------------------------------
// dcce_pkg
// Shared types, field layout and constants of the dimmer channel command engine.
// ----------------------------------------------------------------------------
package dcce_pkg;

    // default number of channel slots in the level store
    localparam int MAX_CHANNELS_DEF = 32;

    // input beat layout, lowest bit first
    localparam int ACT_W   = 2;
    localparam int CHAN_W  = 8;
    localparam int SETV_W  = 16;
    localparam int PCT_W   = 10;
    localparam int DELTA_W = 9;
    localparam int FADE_W  = 3;

    localparam int ACT_LSB   = 0;
    localparam int CHAN_LSB  = ACT_LSB + ACT_W;
    localparam int SETV_LSB  = CHAN_LSB + CHAN_W;
    localparam int PCT_LSB   = SETV_LSB + SETV_W;
    localparam int DELTA_LSB = PCT_LSB + PCT_W;
    localparam int FADE_LSB  = DELTA_LSB + DELTA_W;
    localparam int IN_W      = FADE_LSB + FADE_W;

    localparam int LEVEL_W = 8;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 6;

    // actions
    localparam logic [ACT_W-1:0] ACT_SET    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INVERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_EXP    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_REL    = 2'd3;

    // fade codes and their opcode bytes
    localparam logic [FADE_W-1:0] FADE_IMM     = 3'd0;
    localparam logic [FADE_W-1:0] FADE_SOFT    = 3'd1;
    localparam logic [FADE_W-1:0] FADE_FLASHY  = 3'd2;
    localparam logic [FADE_W-1:0] FADE_IMM_REL = 3'd3;

    localparam logic [BYTE_W-1:0] OP_IMM     = 8'hCF;
    localparam logic [BYTE_W-1:0] OP_SOFT    = 8'hBF;
    localparam logic [BYTE_W-1:0] OP_FLASHY  = 8'hAF;
    localparam logic [BYTE_W-1:0] OP_IMM_REL = 8'h9F;
    localparam logic [BYTE_W-1:0] OP_NONE    = 8'h00;

    localparam logic [PCT_W-1:0]   PCT_UNITY = 10'd100;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'hFF;

    // divide by 100: q = (p * ceil(2^25 / 100)) >> 25, exact for p < 493447
    localparam int                 PROD_W       = LEVEL_W + PCT_W;
    localparam int                 RECIP_W      = 19;
    localparam logic [RECIP_W-1:0] DIV100_RECIP = 19'd335545;
    localparam int                 DIV100_SHIFT = 25;
    localparam int                 SCALED_W     = PROD_W + RECIP_W;
    localparam int                 QUOT_W       = 12;

    // output byte select
    localparam logic [1:0] SEL_OP    = 2'd0;
    localparam logic [1:0] SEL_CHAN  = 2'd1;
    localparam logic [1:0] SEL_LEVEL = 2'd2;

    typedef struct packed {
        logic       capture;  // take the input beat, start the level read
        logic       load;     // latch the current level
        logic       mul;      // level times percent
        logic       div;      // scale product by reciprocal of 100
        logic       wb;       // write the new level back
        logic [1:0] sel;      // output byte select
    } t_cmd;

    typedef struct packed {
        logic present;        // addressed channel exists
    } t_status;

    function automatic logic [BYTE_W-1:0] fade_opcode(input logic [FADE_W-1:0] fade);
        logic [BYTE_W-1:0] op;
        case (fade)
            FADE_IMM:     op = OP_IMM;
            FADE_SOFT:    op = OP_SOFT;
            FADE_FLASHY:  op = OP_FLASHY;
            FADE_IMM_REL: op = OP_IMM_REL;
            default:      op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

// ----- rtl/core/dimmer_channel_command_engine.sv -----
// ----------------------------------------------------------------------------
// dimmer_channel_command_engine
// Per-channel 8-bit dimmer levels updated by commands; each command on a
// present channel sends an opcode byte, the channel and the new level.
// ----------------------------------------------------------------------------
// Channel   Direction  Beat contents
// s_axis    in         action[1:0] channel[9:2] set_value[25:10]
//                      percent[35:26] delta[44:36] fade[47:45]
// m_axis    out        tdata: out_byte; tlast: last (third byte)
// cfg       in         channel_count[5:0]
//
// A present-channel command steps through accept (level store read), level
// latch, level times percent, scaling by 1/100, write-back and three output
// beats. An absent channel is taken and dropped while the engine stays idle.
// Reset clears channel_count and marks every level slot empty, so all levels
// read zero at once. A stall on m_axis holds the current byte and keeps
// s_axis tready low.
// ----------------------------------------------------------------------------
module dimmer_channel_command_engine #(
    parameter int MAX_CHANNELS = dcce_pkg::MAX_CHANNELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [dcce_pkg::IN_W-1:0]     i_s_axis_tdata,   // action, channel, set_value,
                                                            // percent, delta, fade
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [dcce_pkg::BYTE_W-1:0]   o_m_axis_tdata,   // out_byte
    output logic                          o_m_axis_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dcce_pkg::COUNT_W-1:0]  i_cfg_data        // channel_count
);
    import dcce_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    dcce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_last  (o_m_axis_tlast),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    dcce_dp #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_s_axis_tdata),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_byte     (o_m_axis_tdata)
    );

endmodule

// ----- rtl/core/dcce_ram.sv -----
// ----------------------------------------------------------------------------
// dcce_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dcce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/dcce_dp.sv -----
// ----------------------------------------------------------------------------
// dcce_dp
// Datapath: channel count register, level store, level arithmetic and the
// three output bytes.
// ----------------------------------------------------------------------------
module dcce_dp #(
    parameter int MAX_CHANNELS = dcce_pkg::MAX_CHANNELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [dcce_pkg::IN_W-1:0]      i_item,
    input  logic                           i_cfg_we,
    input  logic [dcce_pkg::COUNT_W-1:0]   i_cfg_data,
    input  dcce_pkg::t_cmd                 i_cmd,
    output dcce_pkg::t_status              o_status,
    output logic [dcce_pkg::BYTE_W-1:0]    o_byte
);
    import dcce_pkg::*;

    localparam int                AW         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [CHAN_W:0]   CHAN_LIMIT = (CHAN_W + 1)'(MAX_CHANNELS);

    logic [ACT_W-1:0]    w_action;
    logic [CHAN_W-1:0]   w_chan;
    logic [SETV_W-1:0]   w_setv;
    logic [PCT_W-1:0]    w_pct;
    logic [DELTA_W-1:0]  w_delta;
    logic [FADE_W-1:0]   w_fade;

    logic [COUNT_W-1:0]  r_channel_count;
    logic [MAX_CHANNELS-1:0] r_valid;

    logic [ACT_W-1:0]    r_action;
    logic [CHAN_W-1:0]   r_chan;
    logic [SETV_W-1:0]   r_setv;
    logic [PCT_W-1:0]    r_pct;
    logic [DELTA_W-1:0]  r_delta;
    logic [FADE_W-1:0]   r_fade;
    logic [LEVEL_W-1:0]  r_cur;
    logic [PROD_W-1:0]   r_prod;
    logic [QUOT_W-1:0]   r_quot;
    logic [LEVEL_W-1:0]  r_level;
    logic [LEVEL_W-1:0]  n_level;

    logic [LEVEL_W-1:0]  w_rdata;
    logic [SCALED_W-1:0] w_scaled;
    logic [LEVEL_W-1:0]  w_quot_sat;
    logic signed [LEVEL_W+1:0] w_sum;

    assign w_action = i_item[ACT_LSB +: ACT_W];
    assign w_chan   = i_item[CHAN_LSB +: CHAN_W];
    assign w_setv   = i_item[SETV_LSB +: SETV_W];
    assign w_pct    = i_item[PCT_LSB +: PCT_W];
    assign w_delta  = i_item[DELTA_LSB +: DELTA_W];
    assign w_fade   = i_item[FADE_LSB +: FADE_W];

    assign o_status.present = (CHAN_W'(r_channel_count) > w_chan) &&
                              ({1'b0, w_chan} < CHAN_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= '0;
            r_valid         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_channel_count <= i_cfg_data;
            end
            if (i_cmd.wb) begin
                r_valid[r_chan[AW-1:0]] <= 1'b1;
            end
        end
    end

    dcce_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (MAX_CHANNELS),
        .AW    (AW)
    ) u_levels (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wb),
        .i_waddr (r_chan[AW-1:0]),
        .i_wdata (n_level),
        .i_re    (i_cmd.capture),
        .i_raddr (w_chan[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_scaled = SCALED_W'(r_prod) * SCALED_W'(DIV100_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= w_action;
            r_chan   <= w_chan;
            r_setv   <= w_setv;
            r_pct    <= w_pct;
            r_delta  <= w_delta;
            r_fade   <= w_fade;
        end
        if (i_cmd.load) begin
            // a slot never written reads as zero
            r_cur <= r_valid[r_chan[AW-1:0]] ? w_rdata : '0;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_cur) * PROD_W'(r_pct);
        end
        if (i_cmd.div) begin
            r_quot <= w_scaled[DIV100_SHIFT +: QUOT_W];
        end
        if (i_cmd.wb) begin
            r_level <= n_level;
        end
    end

    assign w_quot_sat = (|r_quot[QUOT_W-1:LEVEL_W]) ? LEVEL_MAX : r_quot[LEVEL_W-1:0];
    assign w_sum      = $signed({2'b00, r_cur}) + $signed({r_delta[DELTA_W-1], r_delta});

    always_comb begin
        n_level = r_cur;
        case (r_action)
            ACT_SET: begin
                n_level = (|r_setv[SETV_W-1:LEVEL_W]) ? LEVEL_MAX : r_setv[LEVEL_W-1:0];
            end
            ACT_INVERT: begin
                n_level = LEVEL_MAX - r_cur;
            end
            ACT_EXP: begin
                if (r_pct > PCT_UNITY) begin
                    // boost: dark levels step up instead of staying stuck
                    if (r_cur == LEVEL_W'(0)) begin
                        n_level = LEVEL_W'(1);
                    end else if (r_cur == LEVEL_W'(1)) begin
                        n_level = LEVEL_W'(2);
                    end else begin
                        n_level = w_quot_sat;
                    end
                end else begin
                    if (r_cur <= LEVEL_W'(1)) begin
                        n_level = '0;
                    end else begin
                        n_level = w_quot_sat;
                    end
                end
            end
            ACT_REL: begin
                if (w_sum[LEVEL_W+1]) begin
                    n_level = '0;
                end else if (w_sum[LEVEL_W]) begin
                    n_level = LEVEL_MAX;
                end else begin
                    n_level = w_sum[LEVEL_W-1:0];
                end
            end
            default: begin
                n_level = r_cur;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.sel)
            SEL_OP:    o_byte = fade_opcode(r_fade);
            SEL_CHAN:  o_byte = r_chan;
            SEL_LEVEL: o_byte = r_level;
            default:   o_byte = r_level;
        endcase
    end

endmodule

// ----- rtl/core/dcce_ctrl.sv -----
// ----------------------------------------------------------------------------
// dcce_ctrl
// Controller: sequences read, multiply, scale, write-back and the three
// output beats of one command.
// ----------------------------------------------------------------------------
module dcce_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_out_last,
    input  dcce_pkg::t_status i_status,
    output dcce_pkg::t_cmd    o_cmd
);
    import dcce_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;
    localparam logic [2:0] S_B0   = 3'd5;
    localparam logic [2:0] S_B1   = 3'd6;
    localparam logic [2:0] S_B2   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_B0) || (r_state == S_B1) || (r_state == S_B2);
    assign o_out_last  = (r_state == S_B2);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.sel = SEL_LEVEL;
        case (r_state)
            S_IDLE: begin
                // absent channels are accepted and dropped
                if (i_in_valid && i_status.present) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = S_WB;
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                n_state  = S_B0;
            end
            S_B0: begin
                o_cmd.sel = SEL_OP;
                if (i_out_ready) begin
                    n_state = S_B1;
                end
            end
            S_B1: begin
                o_cmd.sel = SEL_CHAN;
                if (i_out_ready) begin
                    n_state = S_B2;
                end
            end
            S_B2: begin
                o_cmd.sel = SEL_LEVEL;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input taken while a command is still being sent");

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.capture, o_cmd.load, o_cmd.mul, o_cmd.div, o_cmd.wb}))
        else $error("more than one datapath step in a cycle");

    a_wb_then_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wb |=> (o_out_valid && (o_cmd.sel == SEL_OP)))
        else $error("opcode beat does not follow write-back");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_last && i_out_ready) |=> (o_in_ready && !o_out_valid))
        else $error("engine not idle after last beat");
`endif

endmodule

// ----- sim/dimmer_channel_command_engine_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dimmer_channel_command_engine_test
// Drives dimmer commands into the engine under several channel counts, keeps
// its own copy of the channel levels, and checks every output byte (opcode,
// channel, level, tlast) against the predicted sequence. Both stream sides
// idle at random, and the byte receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module dimmer_channel_command_engine_test;
    import dcce_pkg::*;

    localparam int LEVEL_SLOTS = MAX_CHANNELS_DEF;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AFTER = 120;

    // command beat, highest field first so that action lands in the low bits
    typedef struct packed {
        logic [FADE_W-1:0]         fade;
        logic signed [DELTA_W-1:0] delta;
        logic [PCT_W-1:0]          percent;
        logic [SETV_W-1:0]         set_value;
        logic [CHAN_W-1:0]         channel;
        logic [ACT_W-1:0]          action;
    } t_dimmer_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_out_byte;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_ready;
    t_dimmer_cmd        cmd_data = '0;
    logic               byte_valid;
    logic               byte_ready = 1'b0;
    logic [BYTE_W-1:0]  byte_data;
    logic               byte_last;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data = '0;

    t_dimmer_cmd        cmd_queue[$];
    t_out_byte          expected_bytes[$];
    logic [LEVEL_W-1:0] level_store[LEVEL_SLOTS];
    logic [COUNT_W-1:0] present_count = '0;
    logic               cmd_taken = 1'b0;
    int                 cmds_taken = 0;
    int                 errors = 0;
    int                 idle_pct = 30;
    int                 cmd_gap = 0;
    int                 stall_left = 0;
    int                 hold_left = 0;
    logic               hold_done = 1'b0;
    int                 quiet_cycles = 0;

    dimmer_channel_command_engine dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (cmd_valid),
        .o_s_axis_tready (cmd_ready),
        .i_s_axis_tdata  (cmd_data),
        .o_m_axis_tvalid (byte_valid),
        .i_m_axis_tready (byte_ready),
        .o_m_axis_tdata  (byte_data),
        .o_m_axis_tlast  (byte_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < LEVEL_SLOTS; i++) level_store[i] = '0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 99) >= idle_pct) return 0;
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_dimmer_cmd make_cmd(input logic [ACT_W-1:0] action,
                                             input int channel, input int set_value,
                                             input int percent, input int delta,
                                             input logic [FADE_W-1:0] fade);
        t_dimmer_cmd c;
        c.action    = action;
        c.channel   = channel[CHAN_W-1:0];
        c.set_value = set_value[SETV_W-1:0];
        c.percent   = percent[PCT_W-1:0];
        c.delta     = delta[DELTA_W-1:0];
        c.fade      = fade;
        return c;
    endfunction

    // mostly present channels so that levels build up over a run
    function automatic t_dimmer_cmd random_cmd(input int present);
        t_dimmer_cmd c;
        int          top;
        top = (present > LEVEL_SLOTS) ? LEVEL_SLOTS : present;
        c.action = ACT_W'($urandom_range(0, 3));
        if (top > 0 && $urandom_range(0, 9) < 8)
            c.channel = CHAN_W'($urandom_range(0, top - 1));
        else
            c.channel = CHAN_W'($urandom_range(0, 255));
        c.set_value = ($urandom_range(0, 1) != 0) ? SETV_W'($urandom_range(0, 300))
                                                  : SETV_W'($urandom_range(0, 65535));
        c.percent   = ($urandom_range(0, 3) != 0) ? PCT_W'($urandom_range(0, 200))
                                                  : PCT_W'($urandom_range(0, 1023));
        c.delta     = DELTA_W'($urandom_range(0, 511));
        c.fade      = FADE_W'($urandom_range(0, 7));
        return c;
    endfunction

    // update the level of the addressed channel and queue the three bytes
    task automatic predict_command(input t_dimmer_cmd c);
        int                unsigned cur;
        int                unsigned nv;
        int                sum;
        logic [BYTE_W-1:0] opcode;
        if (c.channel >= present_count || 32'(c.channel) >= LEVEL_SLOTS) return;
        cur = 32'(level_store[c.channel]);
        case (c.action)
            ACT_SET: begin
                nv = (c.set_value > 16'(LEVEL_MAX)) ? 32'(LEVEL_MAX) : 32'(c.set_value);
            end
            ACT_INVERT: begin
                nv = 32'(LEVEL_MAX) - cur;
            end
            ACT_EXP: begin
                if (c.percent > PCT_UNITY)
                    nv = (cur == 0) ? 1 : (cur == 1) ? 2 :
                         cur * 32'(c.percent) / 32'(PCT_UNITY);
                else
                    nv = (cur <= 1) ? 0 : cur * 32'(c.percent) / 32'(PCT_UNITY);
                if (nv > 32'(LEVEL_MAX)) nv = 32'(LEVEL_MAX);
            end
            default: begin
                sum = int'(cur) + int'(c.delta);
                nv = (sum < 0) ? 0 : (sum > int'(LEVEL_MAX)) ? 32'(LEVEL_MAX) : 32'(sum);
            end
        endcase
        level_store[c.channel] = nv[LEVEL_W-1:0];
        case (c.fade)
            FADE_IMM:     opcode = OP_IMM;
            FADE_SOFT:    opcode = OP_SOFT;
            FADE_FLASHY:  opcode = OP_FLASHY;
            FADE_IMM_REL: opcode = OP_IMM_REL;
            default:      opcode = OP_NONE;
        endcase
        expected_bytes.push_back('{data: opcode, last: 1'b0});
        expected_bytes.push_back('{data: c.channel, last: 1'b0});
        expected_bytes.push_back('{data: nv[BYTE_W-1:0], last: 1'b1});
    endtask

    // command driver: advance to the next beat once the current one is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_valid <= 1'b0;
        end else if (!cmd_valid || cmd_taken) begin
            if (cmd_gap > 0) begin
                cmd_valid <= 1'b0;
                cmd_gap <= cmd_gap - 1;
            end else if (cmd_queue.size() > 0) begin
                cmd_valid <= 1'b1;
                cmd_data <= cmd_queue.pop_front();
                cmd_gap <= pick_gap();
            end else begin
                cmd_valid <= 1'b0;
            end
        end
    end

    // byte receiver: random stalls, plus one long hold-off mid-run
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            byte_ready <= 1'b0;
        end else if (hold_left > 0) begin
            byte_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && cmds_taken >= HOLD_OFF_AFTER) begin
            byte_ready <= 1'b0;
            hold_done <= 1'b1;
            hold_left <= HOLD_OFF_CYCLES;
        end else if (stall_left > 0) begin
            byte_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            byte_ready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // monitor: predict on accepted commands, check accepted bytes
    always @(posedge i_clk) begin
        t_out_byte want;
        cmd_taken <= i_rst_n && cmd_valid && cmd_ready;
        if (i_rst_n) begin
            if (cfg_valid && cfg_ready) present_count = cfg_data;
            if (cmd_valid && cmd_ready) begin
                cmds_taken++;
                predict_command(cmd_data);
            end
            if (byte_valid && byte_ready) begin
                if (expected_bytes.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected beat: expected none, actual data %02h last %0b",
                             $time, byte_data, byte_last);
                end else begin
                    want = expected_bytes.pop_front();
                    if (byte_data !== want.data) begin
                        errors++;
                        $display("%0t: data mismatch: expected %02h, actual %02h",
                                 $time, want.data, byte_data);
                    end
                    if (byte_last !== want.last) begin
                        errors++;
                        $display("%0t: tlast mismatch: expected %0b, actual %0b",
                                 $time, want.last, byte_last);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((cmd_valid && cmd_ready) || (byte_valid && byte_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // wait for the queued commands and their bytes, then let dropped ones drain
    task automatic wait_drained();
        while (cmd_queue.size() != 0 || cmd_valid || expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_channel_count(input logic [COUNT_W-1:0] count);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= count;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count, input int n_items, input int idle);
        write_channel_count(count[COUNT_W-1:0]);
        idle_pct = idle;
        for (int i = 0; i < n_items; i++) cmd_queue.push_back(random_cmd(count));
        wait_drained();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // channel count is zero out of reset: every command is dropped
        for (int i = 0; i < 5; i++) cmd_queue.push_back(random_cmd(0));
        wait_drained();

        write_channel_count(6'd32);
        cmd_queue.push_back(make_cmd(ACT_SET,    0,  65535, 0,    0,    FADE_IMM));
        cmd_queue.push_back(make_cmd(ACT_SET,    31, 255,   0,    0,    FADE_SOFT));
        cmd_queue.push_back(make_cmd(ACT_SET,    1,  0,     1023, -256, FADE_FLASHY));
        cmd_queue.push_back(make_cmd(ACT_INVERT, 1,  43690, 0,    0,    FADE_IMM_REL));
        cmd_queue.push_back(make_cmd(ACT_INVERT, 0,  21845, 0,    0,    3'd4));
        // exponential from the special low levels above unity, then at unity and at zero
        cmd_queue.push_back(make_cmd(ACT_EXP,    0,  0,     1023, 0,    3'd7));
        cmd_queue.push_back(make_cmd(ACT_EXP,    0,  0,     101,  0,    3'd5));
        cmd_queue.push_back(make_cmd(ACT_EXP,    0,  0,     1023, 0,    3'd6));
        cmd_queue.push_back(make_cmd(ACT_EXP,    0,  0,     100,  0,    FADE_IMM));
        cmd_queue.push_back(make_cmd(ACT_EXP,    0,  0,     0,    0,    FADE_SOFT));
        // exponential at or below unity drops levels 0 and 1
        cmd_queue.push_back(make_cmd(ACT_SET,    2,  1,     0,    0,    FADE_IMM));
        cmd_queue.push_back(make_cmd(ACT_EXP,    2,  0,     50,   0,    FADE_IMM));
        cmd_queue.push_back(make_cmd(ACT_EXP,    5,  0,     100,  0,    FADE_IMM));
        // saturate the quotient
        cmd_queue.push_back(make_cmd(ACT_SET,    3,  200,   0,    0,    FADE_FLASHY));
        cmd_queue.push_back(make_cmd(ACT_EXP,    3,  0,     1023, 0,    FADE_FLASHY));
        // relative sum saturating low and high
        cmd_queue.push_back(make_cmd(ACT_REL,    3,  0,     0,    -255, FADE_IMM_REL));
        cmd_queue.push_back(make_cmd(ACT_REL,    3,  0,     0,    -1,   FADE_IMM_REL));
        cmd_queue.push_back(make_cmd(ACT_REL,    3,  0,     0,    255,  FADE_IMM_REL));
        cmd_queue.push_back(make_cmd(ACT_REL,    3,  0,     0,    1,    FADE_IMM_REL));
        cmd_queue.push_back(make_cmd(ACT_SET,    4,  256,   0,    0,    FADE_IMM));
        // absent channels, then one present channel
        cmd_queue.push_back(make_cmd(ACT_SET,    32, 7,     0,    0,    FADE_IMM));
        cmd_queue.push_back(make_cmd(ACT_INVERT, 255, 0,    0,    0,    FADE_IMM));
        cmd_queue.push_back(make_cmd(ACT_SET,    31, 17,    0,    0,    FADE_SOFT));
        wait_drained();

        run_random(1, 50, 30);
        run_random(32, 120, 0);
        run_random(31, 60, 40);
        run_random($urandom_range(2, 30), 70, 30);
        run_random(17, 60, 20);
        run_random(0, 10, 30);
        run_random(32, 40, 60);

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
